@@ rtl/core/jbst_pkg.sv @@
// shared types, constants and tables for the json byte stream tokenizer
// no dependencies; used by every module in rtl/core

package jbst_pkg;

  // byte offsets saturate at 2^POS_BITS, so offsets need one extra bit
  localparam int POS_BITS = 24;
  localparam int POS_W    = POS_BITS + 1;

  typedef logic [POS_W-1:0] pos_t;

  localparam pos_t POS_MAX = pos_t'(1) << POS_BITS;

  // token kinds as they appear on the output
  typedef enum logic [3:0] {
    TK_LBRACE   = 4'd0,
    TK_RBRACE   = 4'd1,
    TK_LBRACKET = 4'd2,
    TK_RBRACKET = 4'd3,
    TK_COLON    = 4'd4,
    TK_COMMA    = 4'd5,
    TK_STRING   = 4'd6,
    TK_NUMBER   = 4'd7,
    TK_TRUE     = 4'd8,
    TK_FALSE    = 4'd9,
    TK_NULL     = 4'd10,
    TK_END      = 4'd11,
    TK_ERROR    = 4'd12
  } tok_kind_t;

  // one token, kind in the lowest bits
  typedef struct packed {
    pos_t      length;
    pos_t      start;
    tok_kind_t kind;
  } tok_t;

  localparam int TOK_W     = $bits(tok_t);
  localparam int TDATA_W   = ((TOK_W + 7) / 8) * 8;
  localparam int MAX_TOKS  = 3;

  // all tokens caused by one request, cnt is 1 to 3
  typedef struct packed {
    tok_t [MAX_TOKS-1:0] tok;
    logic [1:0]          cnt;
  } entry_t;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QA     = $clog2(QDEPTH);

  // literal selector
  typedef enum logic [1:0] {
    LIT_TRUE  = 2'd0,
    LIT_FALSE = 2'd1,
    LIT_NULL  = 2'd2,
    LIT_NONE  = 2'd3
  } lit_kind_t;

  // byte codes
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_LOW_E    = 8'h65;
  localparam logic [7:0] CH_UP_E     = 8'h45;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_LOW_T    = 8'h74;
  localparam logic [7:0] CH_LOW_F    = 8'h66;
  localparam logic [7:0] CH_LOW_N    = 8'h6E;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;

  // expected letter after the first one of a literal
  function automatic logic [7:0] lit_char(lit_kind_t k, logic [1:0] g);
    logic [7:0] c;
    c = 8'h00;
    case (k)
      LIT_TRUE: begin
        case (g)
          2'd0:    c = 8'h72;
          2'd1:    c = 8'h75;
          2'd2:    c = 8'h65;
          default: c = 8'h00;
        endcase
      end
      LIT_FALSE: begin
        case (g)
          2'd0:    c = 8'h61;
          2'd1:    c = 8'h6C;
          2'd2:    c = 8'h73;
          default: c = 8'h65;
        endcase
      end
      LIT_NULL: begin
        case (g)
          2'd0:    c = 8'h75;
          2'd1:    c = 8'h6C;
          2'd2:    c = 8'h6C;
          default: c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // progress count at which the literal is complete
  function automatic logic [1:0] lit_last(lit_kind_t k);
    logic [1:0] r;
    case (k)
      LIT_FALSE: r = 2'd3;
      default:   r = 2'd2;
    endcase
    return r;
  endfunction

  // token kind of a literal
  function automatic tok_kind_t lit_tok(lit_kind_t k);
    tok_kind_t r;
    case (k)
      LIT_TRUE:  r = TK_TRUE;
      LIT_FALSE: r = TK_FALSE;
      LIT_NULL:  r = TK_NULL;
      default:   r = TK_ERROR;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/json_byte_stream_tokenizer.sv @@
// top level of the json byte stream tokenizer
// depends on jbst_pkg, jbst_front, jbst_fifo and jbst_back
//
// Usage:
//   Input stream (s_*): one document byte per request. s_tdata[7:0] is the
//   byte, s_tuser flags it as present (0 for an end-only request), s_tlast
//   marks the final request of the document.
//   Output stream (m_*): one token per request, m_tdata packing kind, start
//   and length; m_tlast is high on the final token caused by one input request.
// Timing: the scan step writes a request's tokens into the queue at the edge
//   that takes the byte; the output register then loads them from the queue
//   head in order, one token per load.
// Throughput: one input byte per cycle while the queue has room; the output
//   side moves one token a cycle while m_tready is high, so a request that
//   causes two or three tokens holds the output for each of them in turn,
//   absorbed by the four-deep queue between the scanner and the output stage.
// Reset: clears the scan state, byte position, queue and output valid.
// Stall: while m_tready is low the output token holds; the scanner keeps
//   taking bytes until the queue fills, then s_tready drops.

module json_byte_stream_tokenizer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,  // [7:0] text_byte
  input  logic                         s_tuser,  // [0] byte_present
  input  logic                         s_tlast,  // end_of_document
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // [3:0] token_kind, [28:4] token_start, [53:29] token_length, rest zero
  output logic [jbst_pkg::TDATA_W-1:0] m_tdata,
  output logic                         m_tlast   // last_of_run
);

  logic             q_push, q_full, q_pop, q_head_valid;
  jbst_pkg::entry_t q_data, q_head;

  // scanner
  jbst_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (s_tvalid),
    .text_byte       (s_tdata),
    .byte_present    (s_tuser),
    .end_of_document (s_tlast),
    .in_ready        (s_tready),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_data          (q_data)
  );

  // queue between scanner and output
  jbst_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  // output stage
  jbst_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

@@ rtl/core/jbst_front.sv @@
// front part: scan state machine, classifies each byte and gathers its tokens
// depends on jbst_pkg

module jbst_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [7:0]           text_byte,
  input  logic                 byte_present,
  input  logic                 end_of_document,
  output logic                 in_ready,
  input  logic                 q_full,
  output logic                 q_push,
  output jbst_pkg::entry_t     q_data
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_STR, PH_ESC, PH_LIT, PH_NSIGN, PH_NINT, PH_NDOT,
    PH_NFRAC, PH_NEXP, PH_NESIGN, PH_NEXPD, PH_ERROR
  } phase_t;

  phase_t              scan_phase, scan_phase_next;
  jbst_pkg::pos_t      byte_position, byte_position_next;
  jbst_pkg::pos_t      token_origin, token_origin_next;
  jbst_pkg::lit_kind_t literal_kind, literal_kind_next;
  logic [1:0]          literal_progress, literal_progress_next;
  logic                error_single_byte, error_single_byte_next;

  logic                accept;
  logic                is_dig, is_exp;
  jbst_pkg::pos_t      p, p_inc, endpos, rest;

  // tokens from the idle lexer on this byte
  logic                idle_emit;
  jbst_pkg::tok_kind_t idle_kind;
  phase_t              idle_phase;
  jbst_pkg::lit_kind_t idle_lit;
  logic                idle_err;

  // candidate tokens: two from the byte, two from the end of document
  jbst_pkg::tok_t      cand [4];
  logic [3:0]          cand_v;
  jbst_pkg::entry_t    ent;
  logic [1:0]          n;

  assign accept   = in_valid && in_ready;
  assign in_ready = !q_full;
  assign p        = byte_position;
  assign p_inc    = p + jbst_pkg::pos_t'(1);
  assign is_dig   = (text_byte >= jbst_pkg::CH_ZERO) && (text_byte <= jbst_pkg::CH_NINE);
  assign is_exp   = (text_byte == jbst_pkg::CH_LOW_E) || (text_byte == jbst_pkg::CH_UP_E);

  // classification of a byte between tokens
  always_comb begin
    idle_emit  = 1'b0;
    idle_kind  = jbst_pkg::TK_ERROR;
    idle_phase = PH_IDLE;
    idle_lit   = jbst_pkg::LIT_TRUE;
    idle_err   = 1'b0;
    case (text_byte)
      jbst_pkg::CH_SPACE, jbst_pkg::CH_TAB, jbst_pkg::CH_CR, jbst_pkg::CH_LF: begin
        idle_phase = PH_IDLE;
      end
      jbst_pkg::CH_LBRACE: begin
        idle_emit = 1'b1;
        idle_kind = jbst_pkg::TK_LBRACE;
      end
      jbst_pkg::CH_RBRACE: begin
        idle_emit = 1'b1;
        idle_kind = jbst_pkg::TK_RBRACE;
      end
      jbst_pkg::CH_LBRACKET: begin
        idle_emit = 1'b1;
        idle_kind = jbst_pkg::TK_LBRACKET;
      end
      jbst_pkg::CH_RBRACKET: begin
        idle_emit = 1'b1;
        idle_kind = jbst_pkg::TK_RBRACKET;
      end
      jbst_pkg::CH_COLON: begin
        idle_emit = 1'b1;
        idle_kind = jbst_pkg::TK_COLON;
      end
      jbst_pkg::CH_COMMA: begin
        idle_emit = 1'b1;
        idle_kind = jbst_pkg::TK_COMMA;
      end
      jbst_pkg::CH_QUOTE: idle_phase = PH_STR;
      jbst_pkg::CH_LOW_T: begin
        idle_phase = PH_LIT;
        idle_lit   = jbst_pkg::LIT_TRUE;
      end
      jbst_pkg::CH_LOW_F: begin
        idle_phase = PH_LIT;
        idle_lit   = jbst_pkg::LIT_FALSE;
      end
      jbst_pkg::CH_LOW_N: begin
        idle_phase = PH_LIT;
        idle_lit   = jbst_pkg::LIT_NULL;
      end
      jbst_pkg::CH_MINUS: idle_phase = PH_NSIGN;
      default: begin
        if (is_dig) begin
          idle_phase = PH_NINT;
        end else begin
          idle_phase = PH_ERROR;
          idle_err   = 1'b1;
        end
      end
    endcase
  end

  // next scan state and the tokens of this request
  always_comb begin
    scan_phase_next        = scan_phase;
    byte_position_next     = byte_position;
    token_origin_next      = token_origin;
    literal_kind_next      = literal_kind;
    literal_progress_next  = literal_progress;
    error_single_byte_next = error_single_byte;
    for (int i = 0; i < 4; i++) begin
      cand[i] = '0;
    end
    cand_v = '0;
    endpos = byte_position;
    rest   = '0;

    if (byte_present) begin
      case (scan_phase)
        PH_IDLE: begin
          cand_v[0]          = idle_emit;
          cand[0].kind       = idle_kind;
          cand[0].start      = p;
          cand[0].length     = jbst_pkg::pos_t'(1);
          scan_phase_next    = idle_phase;
          if (idle_phase != PH_IDLE) begin
            token_origin_next = p;
          end
          if (idle_phase == PH_LIT) begin
            literal_kind_next     = idle_lit;
            literal_progress_next = 2'd0;
          end
          if (idle_err) begin
            error_single_byte_next = 1'b1;
          end
        end
        PH_STR: begin
          if (text_byte == jbst_pkg::CH_BSLASH) begin
            scan_phase_next = PH_ESC;
          end else if (text_byte == jbst_pkg::CH_QUOTE) begin
            cand_v[0]       = 1'b1;
            cand[0].kind    = jbst_pkg::TK_STRING;
            cand[0].start   = token_origin;
            cand[0].length  = p_inc - token_origin;
            scan_phase_next = PH_IDLE;
          end
        end
        PH_ESC: scan_phase_next = PH_STR;
        PH_LIT: begin
          if (text_byte == jbst_pkg::lit_char(literal_kind, literal_progress)) begin
            if (literal_progress >= jbst_pkg::lit_last(literal_kind)) begin
              cand_v[0]       = 1'b1;
              cand[0].kind    = jbst_pkg::lit_tok(literal_kind);
              cand[0].start   = token_origin;
              cand[0].length  = p_inc - token_origin;
              scan_phase_next = PH_IDLE;
            end else begin
              literal_progress_next = literal_progress + 2'd1;
            end
          end else begin
            scan_phase_next        = PH_ERROR;
            error_single_byte_next = 1'b0;
          end
        end
        PH_NSIGN, PH_NDOT, PH_NESIGN, PH_NEXP: begin
          if (is_dig) begin
            case (scan_phase)
              PH_NSIGN: scan_phase_next = PH_NINT;
              PH_NDOT:  scan_phase_next = PH_NFRAC;
              default:  scan_phase_next = PH_NEXPD;
            endcase
          end else if ((scan_phase == PH_NEXP) &&
                       ((text_byte == jbst_pkg::CH_PLUS) ||
                        (text_byte == jbst_pkg::CH_MINUS))) begin
            scan_phase_next = PH_NESIGN;
          end else begin
            scan_phase_next        = PH_ERROR;
            error_single_byte_next = 1'b0;
          end
        end
        PH_NINT, PH_NFRAC, PH_NEXPD: begin
          if (is_dig) begin
            scan_phase_next = scan_phase;
          end else if ((scan_phase == PH_NINT) && (text_byte == jbst_pkg::CH_DOT)) begin
            scan_phase_next = PH_NDOT;
          end else if ((scan_phase != PH_NEXPD) && is_exp) begin
            scan_phase_next = PH_NEXP;
          end else begin
            // number closes, the byte is lexed afresh
            cand_v[0]       = 1'b1;
            cand[0].kind    = jbst_pkg::TK_NUMBER;
            cand[0].start   = token_origin;
            cand[0].length  = p - token_origin;
            cand_v[1]       = idle_emit;
            cand[1].kind    = idle_kind;
            cand[1].start   = p;
            cand[1].length  = jbst_pkg::pos_t'(1);
            scan_phase_next = idle_phase;
            if (idle_phase != PH_IDLE) begin
              token_origin_next = p;
            end
            if (idle_phase == PH_LIT) begin
              literal_kind_next     = idle_lit;
              literal_progress_next = 2'd0;
            end
            if (idle_err) begin
              error_single_byte_next = 1'b1;
            end
          end
        end
        default: scan_phase_next = scan_phase;
      endcase
      byte_position_next = (p < jbst_pkg::POS_MAX) ? p_inc : jbst_pkg::POS_MAX;
    end

    // end of document: flush pending token, then end token, then restart
    if (end_of_document) begin
      endpos = byte_position_next;
      rest   = endpos - token_origin_next;
      cand[2].start  = token_origin_next;
      cand[2].length = rest;
      case (scan_phase_next)
        PH_IDLE: cand_v[2] = 1'b0;
        PH_NINT, PH_NFRAC, PH_NEXPD: begin
          cand_v[2]    = 1'b1;
          cand[2].kind = jbst_pkg::TK_NUMBER;
        end
        PH_ERROR: begin
          cand_v[2]    = 1'b1;
          cand[2].kind = jbst_pkg::TK_ERROR;
          if (error_single_byte_next) begin
            cand[2].length = jbst_pkg::pos_t'(1);
          end
        end
        default: begin
          cand_v[2]    = 1'b1;
          cand[2].kind = jbst_pkg::TK_ERROR;
        end
      endcase
      cand_v[3]              = 1'b1;
      cand[3].kind           = jbst_pkg::TK_END;
      cand[3].start          = endpos;
      cand[3].length         = '0;
      scan_phase_next        = PH_IDLE;
      byte_position_next     = '0;
      token_origin_next      = '0;
      literal_kind_next      = jbst_pkg::LIT_TRUE;
      literal_progress_next  = 2'd0;
      error_single_byte_next = 1'b0;
    end
  end

  // pack the valid candidates into one queue entry
  always_comb begin
    ent = '0;
    n   = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (cand_v[i] && (n < 2'd3)) begin
        ent.tok[n] = cand[i];
        n          = n + 2'd1;
      end
    end
    ent.cnt = n;
  end

  assign q_push = accept && (n != 2'd0);
  assign q_data = ent;

  // scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_phase        <= PH_IDLE;
      byte_position     <= '0;
      token_origin      <= '0;
      literal_kind      <= jbst_pkg::LIT_TRUE;
      literal_progress  <= 2'd0;
      error_single_byte <= 1'b0;
    end else if (accept && (byte_present || end_of_document)) begin
      scan_phase        <= scan_phase_next;
      byte_position     <= byte_position_next;
      token_origin      <= token_origin_next;
      literal_kind      <= literal_kind_next;
      literal_progress  <= literal_progress_next;
      error_single_byte <= error_single_byte_next;
    end
  end

endmodule

@@ rtl/core/jbst_fifo.sv @@
// short queue of token groups between front and back
// depends on jbst_pkg

module jbst_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  jbst_pkg::entry_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output jbst_pkg::entry_t head
);

  jbst_pkg::entry_t               slots [jbst_pkg::QDEPTH];
  logic [jbst_pkg::QA-1:0]        wr_ptr, rd_ptr;
  logic [jbst_pkg::QA:0]          count;

  assign full       = (count == (jbst_pkg::QA+1)'(jbst_pkg::QDEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/core/jbst_back.sv @@
// back part: serialises queued token groups onto the output register
// depends on jbst_pkg

module jbst_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         head_valid,
  input  jbst_pkg::entry_t             head,
  output logic                         pop,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [jbst_pkg::TDATA_W-1:0] m_tdata,
  output logic                         m_tlast
);

  logic [1:0] idx;
  logic       load, grp_last;

  assign load     = head_valid && (!m_tvalid || m_tready);
  assign grp_last = (idx == (head.cnt - 2'd1));
  assign pop      = load && grp_last;

  // output register, one token per cycle while the queue has a group and m_tready allows
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      m_tlast  <= 1'b0;
      idx      <= 2'd0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        m_tlast  <= grp_last;
        idx      <= grp_last ? 2'd0 : idx + 2'd1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= jbst_pkg::TDATA_W'(head.tok[idx]);
    end
  end

endmodule
